>>> design/vtd_pkg.sv
// Package for the vertex transform and perspective divide block.
// Holds default widths and the request kind codes; no dependencies.
package vtd_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_XFORM = 1'b1
   } op_type;

endpackage

>>> design/vtd_mac.sv
// Three-stage multiply-accumulate for one column of the transform.
// Depends on vtd_pkg for defaults.
module vtd_mac import vtd_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int SUM_BITS = 2 * WORD_BITS + FRAC_BITS + 2
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [WORD_BITS-1:0] vx,
   input  logic signed [WORD_BITS-1:0] vy,
   input  logic signed [WORD_BITS-1:0] vz,
   input  logic signed [WORD_BITS-1:0] m0,
   input  logic signed [WORD_BITS-1:0] m1,
   input  logic signed [WORD_BITS-1:0] m2,
   input  logic signed [WORD_BITS-1:0] m3,
   output logic signed [SUM_BITS-1:0]  sum
);

   localparam int PROD_BITS = 2 * WORD_BITS;

   logic signed [PROD_BITS-1:0] p0_ff, p1_ff, p2_ff, p0_in, p1_in, p2_in;
   logic signed [SUM_BITS-1:0]  bias_ff, bias_in;
   logic signed [SUM_BITS-1:0]  s01_ff, s2b_ff, s01_in, s2b_in;
   logic signed [SUM_BITS-1:0]  sum_ff, sum_in;

   always_comb begin
      p0_in   = vx * m0;
      p1_in   = vy * m1;
      p2_in   = vz * m2;
      bias_in = {{(SUM_BITS-WORD_BITS){m3[WORD_BITS-1]}}, m3} <<< FRAC_BITS;
      s01_in  = {{(SUM_BITS-PROD_BITS){p0_ff[PROD_BITS-1]}}, p0_ff}
              + {{(SUM_BITS-PROD_BITS){p1_ff[PROD_BITS-1]}}, p1_ff};
      s2b_in  = {{(SUM_BITS-PROD_BITS){p2_ff[PROD_BITS-1]}}, p2_ff} + bias_ff;
      sum_in  = s01_ff + s2b_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         bias_ff <= bias_in;
         s01_ff  <= s01_in;
         s2b_ff  <= s2b_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

>>> design/vtd_div.sv
// Pipelined restoring divider giving a saturated signed fixed-point quotient.
// One quotient bit per stage; depends on vtd_pkg for defaults.
module vtd_div import vtd_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int SUM_BITS = 2 * WORD_BITS + FRAC_BITS + 2
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [SUM_BITS-1:0]  num,
   input  logic signed [SUM_BITS-1:0]  den,
   output logic signed [WORD_BITS-1:0] quo,
   output logic                        sat
);

   localparam int REM_BITS = SUM_BITS + WORD_BITS + FRAC_BITS;

   logic [REM_BITS-1:0]  rem_ff [0:WORD_BITS];
   logic [SUM_BITS-1:0]  den_ff [0:WORD_BITS];
   logic [WORD_BITS-1:0] q_ff   [0:WORD_BITS];
   logic                 neg_ff [0:WORD_BITS];
   logic                 ovf_ff [0:WORD_BITS];

   logic [SUM_BITS-1:0]  nmag, dmag;
   logic [REM_BITS-1:0]  rem_in, dsh;
   logic                 neg_in, ovf_in;

   // Setup stage: magnitudes, sign, and a check that the quotient fits a word.
   always_comb begin
      nmag   = num[SUM_BITS-1] ? SUM_BITS'(-num) : SUM_BITS'(num);
      dmag   = den[SUM_BITS-1] ? SUM_BITS'(-den) : SUM_BITS'(den);
      neg_in = num[SUM_BITS-1] ^ den[SUM_BITS-1];
      rem_in = {{(REM_BITS-SUM_BITS){1'b0}}, nmag} << FRAC_BITS;
      dsh    = {{(REM_BITS-SUM_BITS){1'b0}}, dmag} << WORD_BITS;
      ovf_in = rem_in >= dsh;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= rem_in;
         den_ff[0] <= dmag;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg_in;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
      localparam int SH = WORD_BITS - 1 - k;
      logic [REM_BITS-1:0]  trial;
      logic                 take;
      always_comb begin
         trial = {{(REM_BITS-SUM_BITS){1'b0}}, den_ff[k]} << SH;
         take  = rem_ff[k] >= trial;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= take ? rem_ff[k] - trial : rem_ff[k];
            q_ff[k+1]   <= q_ff[k] | (take ? (WORD_BITS'(1) << SH) : '0);
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   localparam logic [WORD_BITS-1:0] POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] NEG_MAX = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic [WORD_BITS-1:0] qf, lim;
   logic                 clamp;
   logic signed [WORD_BITS-1:0] quo_ff, quo_in;
   logic                 sat_ff;

   always_comb begin
      qf     = q_ff[WORD_BITS];
      lim    = neg_ff[WORD_BITS] ? NEG_MAX : POS_MAX;
      clamp  = ovf_ff[WORD_BITS] || (qf > lim);
      if (clamp) begin
         quo_in = lim;
      end else begin
         quo_in = neg_ff[WORD_BITS] ? WORD_BITS'(-qf) : qf;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quo_ff <= quo_in;
         sat_ff <= clamp;
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule

>>> design/vertex_transform_divide.sv
// Vertex transform with perspective divide. Write requests (tuser kind 0) load one
// matrix entry and give no response; transform requests give one response of
// x/w, y/w, z/w. One request is taken every cycle while the response side is not
// stalled; a transform passes through the vertex registers, the multiply-accumulate
// stages and the divider, which resolves one quotient bit per pipeline stage. A stall
// at the response side holds the whole pipeline. The matrix resets to the identity.
module vertex_transform_divide import vtd_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int REQ_BITS = ((4 + 4 * WORD_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = ((3 * WORD_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // row, col, entry_value, vx, vy, vz
   input  logic [REQ_BITS-1:0] req_tdata,
   // op
   input  logic [0:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // out_x, out_y, out_z
   output logic [RSP_BITS-1:0] rsp_tdata,
   // w_zero, saturated
   output logic [1:0]          rsp_tuser
);

   localparam int SUM_BITS = 2 * WORD_BITS + FRAC_BITS + 2;
   localparam int DIV_LAT  = WORD_BITS + 2;
   localparam int LAT      = 4 + DIV_LAT;

   logic enable, acc;
   logic [1:0] row, col;
   logic signed [WORD_BITS-1:0] entry, vxi, vyi, vzi;

   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;
   assign acc        = req_tvalid && enable;
   assign row   = req_tdata[1:0];
   assign col   = req_tdata[3:2];
   assign entry = req_tdata[4 +: WORD_BITS];
   assign vxi   = req_tdata[4 + WORD_BITS +: WORD_BITS];
   assign vyi   = req_tdata[4 + 2 * WORD_BITS +: WORD_BITS];
   assign vzi   = req_tdata[4 + 3 * WORD_BITS +: WORD_BITS];

   logic signed [WORD_BITS-1:0] mat_ff [0:3][0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               mat_ff[r][c] <= (r == c) ? WORD_BITS'(1) << FRAC_BITS : '0;
            end
         end
      end else if (acc && op_type'(req_tuser[0]) == OP_WRITE) begin
         mat_ff[row][col] <= entry;
      end
   end

   logic signed [WORD_BITS-1:0] vx_ff, vy_ff, vz_ff;
   logic vld_ff [0:LAT-1];

   always_ff @(posedge clock) begin
      if (enable) begin
         vx_ff <= vxi;
         vy_ff <= vyi;
         vz_ff <= vzi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= req_tvalid && op_type'(req_tuser[0]) == OP_XFORM;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   logic signed [SUM_BITS-1:0] sum [0:3];

   for (genvar c = 0; c < 4; c++) begin : g_col
      vtd_mac #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mac (
         .clock  (clock),
         .enable (enable),
         .vx     (vx_ff),
         .vy     (vy_ff),
         .vz     (vz_ff),
         .m0     (mat_ff[0][c]),
         .m1     (mat_ff[1][c]),
         .m2     (mat_ff[2][c]),
         .m3     (mat_ff[3][c]),
         .sum    (sum[c])
      );
   end

   logic signed [WORD_BITS-1:0] quo [0:2];
   logic [2:0] sat;

   for (genvar c = 0; c < 3; c++) begin : g_div
      vtd_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
         .clock  (clock),
         .enable (enable),
         .num    (sum[c]),
         .den    (sum[3]),
         .quo    (quo[c]),
         .sat    (sat[c])
      );
   end

   // The zero-w flag rides alongside the divider stages.
   logic wz_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (enable) begin
         wz_ff[0] <= sum[3] == '0;
         for (int i = 1; i < DIV_LAT; i++) wz_ff[i] <= wz_ff[i-1];
      end
   end

   logic wz;
   assign wz         = wz_ff[DIV_LAT-1];
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = wz ? '0 : RSP_BITS'({quo[2], quo[1], quo[0]});
   assign rsp_tuser  = {!wz && (|sat), wz};

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken during response stall");

   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      acc && op_type'(req_tuser[0]) == OP_WRITE |=>
      mat_ff[$past(row)][$past(col)] == $past(entry))
      else $error("matrix entry write lost");

   a_xform_enters: assert property (@(posedge clock) disable iff (reset)
      acc && op_type'(req_tuser[0]) == OP_XFORM |=> vld_ff[0])
      else $error("transform request not entered in pipeline");

endmodule

>>> dv/vertex_divide_checker.sv
// Checker for the vertex transform and perspective divide block: watches both
// stream channels, predicts each projected vertex and compares it. Uses vtd_pkg.
module vertex_divide_checker import vtd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic [0:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           failures,
   output int           outstanding,
   output int           xform_count,
   output int           write_count,
   output int           wzero_count,
   output int           sat_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        w_zero;
      logic        saturated;
   } projection_type;

   logic [31:0] matrix [16];
   projection_type expected_projections [$];

   // Truncating divide of exact Q32.32 sums, clamped to the 32-bit range.
   function automatic logic [31:0] divide_clamp(logic signed [127:0] num,
                                                logic signed [127:0] den,
                                                inout logic sat);
      logic        neg;
      logic [127:0] n, d, q, limit;
      neg   = (num < 0) != (den < 0);
      n     = (num < 0) ? -num : num;
      d     = (den < 0) ? -den : den;
      n     = n << 16;
      q     = n / d;
      limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > limit) begin
         sat = 1'b1;
         q   = limit;
      end
      return neg ? -q[31:0] : q[31:0];
   endfunction

   function automatic projection_type project_vertex(logic [31:0] vx, logic [31:0] vy,
                                                     logic [31:0] vz);
      logic signed [127:0] p [3];
      logic signed [127:0] s [4];
      logic signed [127:0] m;
      projection_type r;
      logic sat;
      p[0] = $signed(vx);
      p[1] = $signed(vy);
      p[2] = $signed(vz);
      for (int c = 0; c < 4; c++) begin
         m    = $signed(matrix[12 + c]);
         s[c] = m <<< 16;
         for (int k = 0; k < 3; k++) begin
            m    = $signed(matrix[k * 4 + c]);
            s[c] = s[c] + p[k] * m;
         end
      end
      r   = '0;
      sat = 1'b0;
      if (s[3] == 0) begin
         r.w_zero = 1'b1;
      end else begin
         r.x = divide_clamp(s[0], s[3], sat);
         r.y = divide_clamp(s[1], s[3], sat);
         r.z = divide_clamp(s[2], s[3], sat);
         r.saturated = sat;
      end
      return r;
   endfunction

   assign outstanding = expected_projections.size();

   always @(posedge clock) begin
      projection_type exp_p, got;
      if (reset) begin
         for (int i = 0; i < 16; i++)
            matrix[i] <= ((i >> 2) == (i & 3)) ? 32'h0001_0000 : 32'h0;
         expected_projections.delete();
         failures    <= 0;
         xform_count <= 0;
         write_count <= 0;
         wzero_count <= 0;
         sat_count   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                   rsp_tuser[0], rsp_tuser[1]};
            if (expected_projections.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               failures <= failures + 1;
            end else begin
               exp_p = expected_projections.pop_front();
               if (got !== exp_p) begin
                  $display("%0t: mismatch expected x=%h y=%h z=%h wz=%b sat=%b",
                           $time, exp_p.x, exp_p.y, exp_p.z, exp_p.w_zero,
                           exp_p.saturated);
                  $display("%0t:          actual   x=%h y=%h z=%h wz=%b sat=%b",
                           $time, got.x, got.y, got.z, got.w_zero, got.saturated);
                  failures <= failures + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (op_type'(req_tuser) == OP_WRITE) begin
               matrix[{req_tdata[1:0], req_tdata[3:2]}] <= req_tdata[35:4];
               write_count <= write_count + 1;
            end else begin
               exp_p = project_vertex(req_tdata[67:36], req_tdata[99:68],
                                      req_tdata[131:100]);
               expected_projections.push_back(exp_p);
               xform_count <= xform_count + 1;
               if (exp_p.w_zero) wzero_count <= wzero_count + 1;
               if (exp_p.saturated) sat_count <= sat_count + 1;
            end
         end
      end
   end
endmodule

>>> dv/vertex_transform_divide_tb.sv
// Top of the vertex transform and perspective divide testbench: clock, reset, request
// stimulus and response back-pressure. Needs vtd_pkg, vertex_transform_divide and vertex_divide_checker.
module vertex_transform_divide_tb import vtd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [0:0]   req_tuser = OP_WRITE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   int  failures, outstanding, xform_count, write_count, wzero_count, sat_count;
   int  sent = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   bit  long_hold = 1'b0;
   bit  hold_done = 1'b0;

   always #5 clock = ~clock;

   vertex_transform_divide u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   vertex_divide_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .failures, .outstanding, .xform_count, .write_count, .wzero_count, .sat_count
   );

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 4))
         0, 1: return $urandom;
         2: return 32'($signed($urandom_range(0, 'h7_ffff)) - 'h4_0000);
         3: return $urandom >> $urandom_range(0, 31);
         default: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               3: return 32'h0001_0000;
               4: return 32'hffff_0000;
               default: return 32'h0;
            endcase
         end
      endcase
   endfunction

   // Offers one request and returns once it has been taken.
   task automatic send_request(op_type op, logic [1:0] row, logic [1:0] col,
                               logic [31:0] entry, logic [31:0] vx,
                               logic [31:0] vy, logic [31:0] vz);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, vz, vy, vx, entry, col, row};
      do @(posedge clock); while (!req_tready);
      sent++;
      if (sent == 400) long_hold = 1'b1;
      if (sent > 1400) quiet = 1'b1;
   endtask

   task automatic write_entry(int r, int c, logic [31:0] v);
      send_request(OP_WRITE, 2'(r), 2'(c), v, $urandom, $urandom, $urandom);
   endtask

   task automatic transform(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      send_request(OP_XFORM, 2'($urandom), 2'($urandom), $urandom, vx, vy, vz);
   endtask

   // Response side back-pressure, with one long hold-off to fill the pipeline.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_done = 1'b1;
            rsp_tready <= 1'b1;
         end else if (!quiet && !reset && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == 5000) begin
         $display("vertex_transform_divide regression: fail");
         $finish;
      end
   end

   initial begin
      int wait_cycles;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity matrix at the coordinate extremes.
      transform(32'h0, 32'h0, 32'h0);
      transform(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      transform(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
      // A tiny w makes both nonzero quotients of this vertex overflow.
      write_entry(3, 3, 32'h0000_0001);
      transform(32'h0100_0000, 32'hff00_0000, 32'h0);
      // Negative w flips the signs.
      write_entry(3, 3, 32'hffff_0000);
      transform(32'h0003_8000, 32'hfffc_8000, 32'h0000_0001);
      // w exactly zero for any vertex.
      write_entry(3, 3, 32'h0);
      transform(32'h0, 32'h0, 32'h0);
      transform(32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff);
      // w driven by the vertex: zero at vx = 1.0 with a -1.0 offset.
      write_entry(0, 3, 32'h0001_0000);
      write_entry(3, 3, 32'hffff_0000);
      transform(32'h0001_0000, 32'h5555_0000, 32'h8000_0000);
      transform(32'h0002_0000, 32'h7fff_ffff, 32'h8000_0000);
      write_entry(1, 0, 32'h8000_0000);
      write_entry(2, 2, 32'h7fff_ffff);
      transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      transform(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);

      // Random: mostly transforms, entry writes mixed in, and occasional
      // forced zero-w column to reach that case.
      while (sent < 1550) begin
         case ($urandom_range(0, 29))
            0: begin
               for (int r = 0; r < 4; r++) write_entry(r, 3, 32'h0);
               transform(pick_word(), pick_word(), pick_word());
               write_entry(3, 3, pick_word());
            end
            1, 2, 3, 4, 5, 6, 7:
               write_entry($urandom_range(0, 3), $urandom_range(0, 3), pick_word());
            default: transform(pick_word(), pick_word(), pick_word());
         endcase
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (outstanding != 0) begin
         @(posedge clock);
         wait_cycles++;
         if (wait_cycles == 20000) begin
            $display("vertex_transform_divide regression: fail");
            $finish;
         end
      end
      repeat (60) @(posedge clock);
      $display("Covered %0d vertex transforms and %0d matrix entry writes.",
               xform_count, write_count);
      $display("Zero-w responses: %0d, saturated responses: %0d.", wzero_count, sat_count);
      if (failures == 0 && outstanding == 0)
         $display("vertex_transform_divide regression: pass");
      else
         $display("vertex_transform_divide regression: fail");
      $finish;
   end
endmodule

>>> filelist.f
design/vtd_pkg.sv
design/vtd_mac.sv
design/vtd_div.sv
design/vertex_transform_divide.sv
dv/vertex_divide_checker.sv
dv/vertex_transform_divide_tb.sv
